>>> rtl/c2rs_pkg.sv
`timescale 1ns / 1ps

package c2rs_pkg;

   // Block dimensions and arithmetic format.
   localparam int FILTER_COUNT = 8;
   localparam int KERNEL_SIZE  = 3;
   localparam int IMAGE_ROWS   = 16;
   localparam int IMAGE_COLS   = 64;
   localparam int DATA_WIDTH   = 16;
   localparam int FRAC_BITS    = 8;

   // Derived sizes.
   localparam int TAPS       = KERNEL_SIZE * KERNEL_SIZE;
   localparam int LINES      = KERNEL_SIZE - 1;
   localparam int LANES      = TAPS + 1;
   localparam int GROUP_SIZE = 4;
   localparam int GROUPS     = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int FSEL_W     = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;
   localparam int LANE_W     = $clog2(LANES);
   localparam int ROW_CNT_W  = $clog2(IMAGE_ROWS);
   localparam int COL_CNT_W  = $clog2(IMAGE_COLS);
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int PROD_EXT_W = PROD_W + FRAC_BITS;

   // Result queue sizing.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int CRED_W    = $clog2(RSP_DEPTH + 1);

   // Fixed field widths of the beats.
   localparam int CMD_W   = 2;
   localparam int FILT_W  = 3;
   localparam int TAP_W   = 2;
   localparam int VALUE_W = 16;
   localparam int OROW_W  = 4;
   localparam int OCOL_W  = 6;
   localparam int ACT_W   = 15;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_WEIGHT = 2'd1,
      CMD_BIAS   = 2'd2
   } cmd_type;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [TAPS-1:0][DATA_WIDTH-1:0] win_type;
   typedef logic [LANES-1:0][DATA_WIDTH-1:0] coef_row_type;
   typedef logic [LINES-1:0][DATA_WIDTH-1:0] line_ent_type;
   typedef logic [GROUPS-1:0][DATA_WIDTH-1:0] grp_type;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [FILT_W-1:0]         filter_index;
      logic [TAP_W-1:0]          tap_row;
      logic [TAP_W-1:0]          tap_col;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [FILT_W-1:0] filter_id;
      logic [OROW_W-1:0] out_row;
      logic [OCOL_W-1:0] out_col;
      logic [ACT_W-1:0]  activation;
      logic              last_of_run;
   } rsp_type;

   // Window update handed from the line buffer to the filter sequencer.
   typedef struct packed {
      logic              emit;
      logic [OROW_W-1:0] out_row;
      logic [OCOL_W-1:0] out_col;
   } win_evt_type;

   // One lane write into the coefficient memory.
   typedef struct packed {
      logic              en;
      logic [FSEL_W-1:0] row;
      logic [LANE_W-1:0] lane;
      data_type          data;
   } coef_wr_type;

   // Sign-extend the beat value and wrap it to the data width.
   function automatic data_type to_data(input logic signed [VALUE_W-1:0] v);
      logic signed [63:0] x;
      x = 64'(v);
      return x[DATA_WIDTH-1:0];
   endfunction

endpackage

>>> rtl/c2rs_line_win.sv
`timescale 1ns / 1ps

module c2rs_line_win (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  smp_valid,
   output logic                  smp_ready,
   input  c2rs_pkg::data_type    smp_data,
   output logic                  evt_valid,
   input  logic                  evt_ready,
   output c2rs_pkg::win_evt_type evt,
   output c2rs_pkg::win_type     win
);

   logic [c2rs_pkg::ROW_CNT_W-1:0] row_ff, row_in;
   logic [c2rs_pkg::COL_CNT_W-1:0] col_ff, col_in;
   logic                           filled_ff, filled_in;
   logic                           s1_valid_ff, s1_valid_in;
   c2rs_pkg::data_type             s1_value_ff;
   logic [c2rs_pkg::ROW_CNT_W-1:0] s1_row_ff;
   logic [c2rs_pkg::COL_CNT_W-1:0] s1_col_ff;
   logic                           rd_ok_ff;
   c2rs_pkg::line_ent_type         rd_ff;
   c2rs_pkg::win_type              win_ff, win_in;
   c2rs_pkg::line_ent_type         line_data;
   c2rs_pkg::line_ent_type         new_ent;
   c2rs_pkg::line_ent_type         line_mem [c2rs_pkg::IMAGE_COLS];
   logic                           acc;
   logic                           hand;
   logic                           col_last;
   logic                           row_last;

   assign smp_ready = !s1_valid_ff || evt_ready;
   assign acc       = smp_valid && smp_ready;
   assign hand      = s1_valid_ff && evt_ready;
   assign evt_valid = s1_valid_ff;
   assign win       = win_ff;

   // Raster position of the next sample.
   assign col_last = (col_ff == c2rs_pkg::COL_CNT_W'(c2rs_pkg::IMAGE_COLS - 1));
   assign row_last = (row_ff == c2rs_pkg::ROW_CNT_W'(c2rs_pkg::IMAGE_ROWS - 1));

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      filled_in   = filled_ff;
      s1_valid_in = s1_valid_ff;
      if (hand) begin
         s1_valid_in = 1'b0;
      end
      if (acc) begin
         s1_valid_in = 1'b1;
         if (col_last) begin
            col_in    = '0;
            filled_in = 1'b1;
            row_in    = row_last ? '0 : c2rs_pkg::ROW_CNT_W'(row_ff + 1'b1);
         end else begin
            col_in = c2rs_pkg::COL_CNT_W'(col_ff + 1'b1);
         end
      end
   end

   // Line entries read before any full row was stored read as zero.
   assign line_data = rd_ok_ff ? rd_ff : '0;

   // Shift the column of stored lines up and append the sample.
   always_comb begin
      for (int k = 0; k < c2rs_pkg::LINES - 1; k++) begin
         new_ent[k] = line_data[k + 1];
      end
      new_ent[c2rs_pkg::LINES-1] = s1_value_ff;
   end

   // Shift the window one column left and insert the new column.
   always_comb begin
      for (int r = 0; r < c2rs_pkg::KERNEL_SIZE; r++) begin
         for (int c = 0; c < c2rs_pkg::KERNEL_SIZE - 1; c++) begin
            win_in[r*c2rs_pkg::KERNEL_SIZE + c] = win_ff[r*c2rs_pkg::KERNEL_SIZE + c + 1];
         end
      end
      for (int r = 0; r < c2rs_pkg::LINES; r++) begin
         win_in[r*c2rs_pkg::KERNEL_SIZE + c2rs_pkg::KERNEL_SIZE - 1] = line_data[r];
      end
      win_in[c2rs_pkg::TAPS-1] = s1_value_ff;
   end

   // Window event for the filter sequencer.
   always_comb begin
      evt.emit    = (s1_row_ff >= c2rs_pkg::ROW_CNT_W'(c2rs_pkg::KERNEL_SIZE - 1)) &&
                    (s1_col_ff >= c2rs_pkg::COL_CNT_W'(c2rs_pkg::KERNEL_SIZE - 1));
      evt.out_row = c2rs_pkg::OROW_W'(c2rs_pkg::ROW_CNT_W'(
                       s1_row_ff - c2rs_pkg::ROW_CNT_W'(c2rs_pkg::KERNEL_SIZE - 1)));
      evt.out_col = c2rs_pkg::OCOL_W'(c2rs_pkg::COL_CNT_W'(
                       s1_col_ff - c2rs_pkg::COL_CNT_W'(c2rs_pkg::KERNEL_SIZE - 1)));
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         filled_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         rd_ok_ff    <= 1'b0;
         win_ff      <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         filled_ff   <= filled_in;
         s1_valid_ff <= s1_valid_in;
         if (acc) begin
            rd_ok_ff <= filled_ff;
         end
         if (hand) begin
            win_ff <= win_in;
         end
      end
   end

   // Sample held while its line column is read.
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_value_ff <= smp_data;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
      end
   end

   // Line memory: read at accept, written back when the window moves.
   always_ff @(posedge clock) begin
      if (acc) begin
         rd_ff <= line_mem[col_ff];
      end
      if (hand) begin
         line_mem[s1_col_ff] <= new_ent;
      end
   end

endmodule

>>> rtl/c2rs_coef_mem.sv
`timescale 1ns / 1ps

module c2rs_coef_mem (
   input  logic                         clock,
   input  logic                         reset,
   input  c2rs_pkg::coef_wr_type        wr,
   input  logic                         ren,
   input  logic [c2rs_pkg::FSEL_W-1:0]  raddr,
   output c2rs_pkg::coef_row_type       rdata
);

   c2rs_pkg::coef_row_type                                 mem [c2rs_pkg::FILTER_COUNT];
   c2rs_pkg::coef_row_type                                 rd_ff;
   logic [c2rs_pkg::FILTER_COUNT-1:0][c2rs_pkg::LANES-1:0] valid_ff;
   logic [c2rs_pkg::LANES-1:0]                             rd_valid_ff;

   // Lane valid bits stand in for clearing the memory at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= '0;
      end else begin
         if (ren) begin
            rd_valid_ff <= valid_ff[raddr];
         end
         if (wr.en) begin
            valid_ff[wr.row][wr.lane] <= 1'b1;
         end
      end
   end

   // One row per filter: the weights and then the bias, one lane written per load.
   always_ff @(posedge clock) begin
      if (ren) begin
         rd_ff <= mem[raddr];
      end
      if (wr.en) begin
         mem[wr.row][wr.lane] <= wr.data;
      end
   end

   always_comb begin
      for (int k = 0; k < c2rs_pkg::LANES; k++) begin
         rdata[k] = rd_valid_ff[k] ? rd_ff[k] : '0;
      end
   end

endmodule

>>> rtl/c2rs_mac.sv
`timescale 1ns / 1ps

module c2rs_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         evt_valid,
   output logic                         evt_ready,
   input  c2rs_pkg::win_evt_type        evt,
   input  c2rs_pkg::win_type            win,
   output logic                         coef_ren,
   output logic [c2rs_pkg::FSEL_W-1:0]  coef_raddr,
   input  c2rs_pkg::coef_row_type       coef_rd,
   input  logic                         rsp_pop,
   output logic                         res_valid,
   output c2rs_pkg::rsp_type            res
);

   logic                           busy_ff, busy_in;
   logic [c2rs_pkg::FSEL_W-1:0]    fcnt_ff, fcnt_in;
   logic [c2rs_pkg::CRED_W-1:0]    cred_ff, cred_in;
   logic [c2rs_pkg::OROW_W-1:0]    row_ff;
   logic [c2rs_pkg::OCOL_W-1:0]    col_ff;
   logic                           issue;
   logic                           last;
   logic                           evt_acc;
   logic                           s1_valid_ff;
   logic                           s2_valid_ff;
   logic                           s3_valid_ff;
   c2rs_pkg::rsp_type              s1_tag_ff, s1_tag_in;
   c2rs_pkg::rsp_type              s2_tag_ff;
   c2rs_pkg::rsp_type              s3_tag_ff;
   c2rs_pkg::win_type              win_s1_ff;
   c2rs_pkg::coef_row_type         terms_s2_in, terms_s2_ff;
   c2rs_pkg::grp_type              grp_s3_in, grp_s3_ff;
   c2rs_pkg::data_type             total;

   // Filter sequencer: one filter per cycle while result credits remain.
   assign issue     = busy_ff && (cred_ff < c2rs_pkg::CRED_W'(c2rs_pkg::RSP_DEPTH));
   assign last      = (fcnt_ff == c2rs_pkg::FSEL_W'(c2rs_pkg::FILTER_COUNT - 1));
   assign evt_ready = !busy_ff || (issue && last);
   assign evt_acc   = evt_valid && evt_ready;

   assign coef_ren   = issue;
   assign coef_raddr = fcnt_ff;

   always_comb begin
      busy_in = busy_ff;
      fcnt_in = fcnt_ff;
      if (issue) begin
         fcnt_in = c2rs_pkg::FSEL_W'(fcnt_ff + 1'b1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (evt_acc) begin
         busy_in = evt.emit;
         fcnt_in = '0;
      end
      cred_in = c2rs_pkg::CRED_W'(cred_ff + c2rs_pkg::CRED_W'(issue)
                                  - c2rs_pkg::CRED_W'(rsp_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         fcnt_ff     <= '0;
         cred_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         fcnt_ff     <= fcnt_in;
         cred_ff     <= cred_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Position of the window being worked on.
   always_ff @(posedge clock) begin
      if (evt_acc) begin
         row_ff <= evt.out_row;
         col_ff <= evt.out_col;
      end
   end

   // Issue stage: tag and window travel alongside the coefficient read.
   always_comb begin
      s1_tag_in.filter_id   = c2rs_pkg::FILT_W'(fcnt_ff);
      s1_tag_in.out_row     = row_ff;
      s1_tag_in.out_col     = col_ff;
      s1_tag_in.activation  = '0;
      s1_tag_in.last_of_run = last;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_tag_ff <= s1_tag_in;
         win_s1_ff <= win;
      end
   end

   // Products, floored by the fraction bits and wrapped; the bias rides in the last lane.
   always_comb begin
      logic signed [c2rs_pkg::PROD_W-1:0]     prod;
      logic signed [c2rs_pkg::PROD_EXT_W-1:0] pext;
      prod = '0;
      pext = '0;
      for (int k = 0; k < c2rs_pkg::TAPS; k++) begin
         prod = $signed(win_s1_ff[k]) * $signed(coef_rd[k]);
         pext = c2rs_pkg::PROD_EXT_W'(prod);
         terms_s2_in[k] = pext[c2rs_pkg::FRAC_BITS +: c2rs_pkg::DATA_WIDTH];
      end
      terms_s2_in[c2rs_pkg::TAPS] = coef_rd[c2rs_pkg::TAPS];
   end

   always_ff @(posedge clock) begin
      s2_tag_ff   <= s1_tag_ff;
      terms_s2_ff <= terms_s2_in;
   end

   // Group sums; every sum wraps to the data width.
   always_comb begin
      for (int g = 0; g < c2rs_pkg::GROUPS; g++) begin
         grp_s3_in[g] = '0;
         for (int i = 0; i < c2rs_pkg::GROUP_SIZE; i++) begin
            if (g * c2rs_pkg::GROUP_SIZE + i < c2rs_pkg::LANES) begin
               grp_s3_in[g] = c2rs_pkg::DATA_WIDTH'(grp_s3_in[g]
                              + terms_s2_ff[g * c2rs_pkg::GROUP_SIZE + i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s3_tag_ff <= s2_tag_ff;
      grp_s3_ff <= grp_s3_in;
   end

   // Final sum and ReLU.
   always_comb begin
      total = '0;
      for (int g = 0; g < c2rs_pkg::GROUPS; g++) begin
         total = c2rs_pkg::DATA_WIDTH'(total + grp_s3_ff[g]);
      end
      res            = s3_tag_ff;
      res.activation = total[c2rs_pkg::DATA_WIDTH-1] ? '0 : c2rs_pkg::ACT_W'(total);
   end

   assign res_valid = s3_valid_ff;

endmodule

>>> rtl/c2rs_rsp_fifo.sv
`timescale 1ns / 1ps

module c2rs_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  c2rs_pkg::rsp_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output c2rs_pkg::rsp_type rd_data
);

   c2rs_pkg::rsp_type               mem_ff [c2rs_pkg::RSP_DEPTH];
   logic [c2rs_pkg::RSP_PTR_W-1:0]  wr_ptr_ff;
   logic [c2rs_pkg::RSP_PTR_W-1:0]  rd_ptr_ff;
   logic [c2rs_pkg::CRED_W-1:0]     cnt_ff;
   logic                            pop;

   // The sequencer's credits keep writes from overrunning the queue.
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_valid) begin
            wr_ptr_ff <= c2rs_pkg::RSP_PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= c2rs_pkg::RSP_PTR_W'(rd_ptr_ff + 1'b1);
         end
         cnt_ff <= c2rs_pkg::CRED_W'(cnt_ff + c2rs_pkg::CRED_W'(wr_valid)
                                     - c2rs_pkg::CRED_W'(pop));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/conv2d_relu_stream.sv
`timescale 1ns / 1ps
// A sample that completes a window occupies the filter sequencer until every filter is
// issued, one coefficient memory row read per filter; each result passes the issue,
// product and group-sum registers into the result queue. Throughput: one result per cycle
// while result credits remain. Other samples and loads are taken one per cycle while the
// sequencer is idle; a load right behind a sample waits for it to leave the line stage.
// Reset is synchronous: line and coefficient memories read as zero until written.

module conv2d_relu_stream (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  c2rs_pkg::req_type req_beat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output c2rs_pkg::rsp_type rsp_beat
);

   logic                          is_sample;
   logic                          is_weight;
   logic                          is_bias;
   logic                          smp_ready;
   logic                          evt_valid;
   logic                          evt_ready;
   c2rs_pkg::win_evt_type         evt;
   c2rs_pkg::win_type             win;
   logic                          load_ok;
   logic                          filt_ok;
   logic                          tap_ok;
   c2rs_pkg::coef_wr_type         coef_wr;
   logic                          coef_ren;
   logic [c2rs_pkg::FSEL_W-1:0]   coef_raddr;
   c2rs_pkg::coef_row_type        coef_rd;
   logic                          res_valid;
   c2rs_pkg::rsp_type             res;
   logic                          rsp_pop;
   c2rs_pkg::data_type            value_d;

   // Command decode.
   assign is_sample = (req_beat.command == c2rs_pkg::CMD_SAMPLE);
   assign is_weight = (req_beat.command == c2rs_pkg::CMD_WEIGHT);
   assign is_bias   = (req_beat.command == c2rs_pkg::CMD_BIAS);
   assign value_d   = c2rs_pkg::to_data(req_beat.value);

   // Loads wait until no earlier sample can still read the coefficients.
   assign load_ok = !evt_valid && evt_ready;

   always_comb begin
      if (is_sample) begin
         req_ready = smp_ready;
      end else if (is_weight || is_bias) begin
         req_ready = load_ok;
      end else begin
         req_ready = 1'b1;
      end
   end

   // Coefficient write for weight and bias loads in range.
   assign filt_ok = (32'(req_beat.filter_index) < c2rs_pkg::FILTER_COUNT);
   assign tap_ok  = (32'(req_beat.tap_row) < c2rs_pkg::KERNEL_SIZE) &&
                    (32'(req_beat.tap_col) < c2rs_pkg::KERNEL_SIZE);

   always_comb begin
      coef_wr.en   = req_valid && req_ready && filt_ok &&
                     ((is_weight && tap_ok) || is_bias);
      coef_wr.row  = c2rs_pkg::FSEL_W'(req_beat.filter_index);
      coef_wr.lane = is_bias ? c2rs_pkg::LANE_W'(c2rs_pkg::TAPS)
                             : c2rs_pkg::LANE_W'(c2rs_pkg::LANE_W'(req_beat.tap_row)
                               * c2rs_pkg::LANE_W'(c2rs_pkg::KERNEL_SIZE)
                               + c2rs_pkg::LANE_W'(req_beat.tap_col));
      coef_wr.data = value_d;
   end

   assign rsp_pop = rsp_valid && rsp_ready;

   c2rs_line_win u_line_win (
      .clock     (clock),
      .reset     (reset),
      .smp_valid (req_valid && is_sample),
      .smp_ready (smp_ready),
      .smp_data  (value_d),
      .evt_valid (evt_valid),
      .evt_ready (evt_ready),
      .evt       (evt),
      .win       (win)
   );

   c2rs_coef_mem u_coef_mem (
      .clock (clock),
      .reset (reset),
      .wr    (coef_wr),
      .ren   (coef_ren),
      .raddr (coef_raddr),
      .rdata (coef_rd)
   );

   c2rs_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (evt_valid),
      .evt_ready  (evt_ready),
      .evt        (evt),
      .win        (win),
      .coef_ren   (coef_ren),
      .coef_raddr (coef_raddr),
      .coef_rd    (coef_rd),
      .rsp_pop    (rsp_pop),
      .res_valid  (res_valid),
      .res        (res)
   );

   c2rs_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (rsp_beat)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

   // Command code that the block does not decode.
   localparam logic [c2rs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_ITEMS = 250;

   typedef logic signed [c2rs_pkg::DATA_WIDTH-1:0] word_type;
   typedef logic signed [c2rs_pkg::VALUE_W-1:0]    value_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   c2rs_pkg::req_type req_beat;
   logic              rsp_valid;
   logic              rsp_ready;
   c2rs_pkg::rsp_type rsp_beat;

   conv2d_relu_stream u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   // Shadow copy of the block state used to work out the expected results.
   word_type          line_mem [c2rs_pkg::LINES][c2rs_pkg::IMAGE_COLS];
   word_type          window [c2rs_pkg::TAPS];
   word_type          weights [c2rs_pkg::FILTER_COUNT][c2rs_pkg::TAPS];
   word_type          biases [c2rs_pkg::FILTER_COUNT];
   int                pos_row;
   int                pos_col;
   c2rs_pkg::rsp_type pending_acts[$];

   int  error_count;
   int  results_checked;
   int  samples_sent;
   int  loads_applied;
   int  beats_ignored;
   bit  req_steady;
   bit  rsp_steady;
   int  hold_requests;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Data value with a bias toward the extremes and toward small magnitudes.
   function automatic value_type pick_value();
      case ($urandom_range(0, 11))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         4, 5, 6: return value_type'($urandom_range(0, 1023) - 512);
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
               what, got, want, results_checked, $realtime);
   endtask

   // Apply one accepted beat to the shadow state and queue the activations it causes.
   task automatic advance_window(input c2rs_pkg::req_type b);
      word_type                                 v;
      word_type                                 acc;
      logic signed [2*c2rs_pkg::DATA_WIDTH-1:0] prod;
      c2rs_pkg::rsp_type                        r;
      v = c2rs_pkg::DATA_WIDTH'(b.value);
      case (b.command)
         c2rs_pkg::CMD_WEIGHT: begin
            if (b.filter_index < c2rs_pkg::FILTER_COUNT &&
                b.tap_row < c2rs_pkg::KERNEL_SIZE &&
                b.tap_col < c2rs_pkg::KERNEL_SIZE) begin
               weights[b.filter_index][b.tap_row * c2rs_pkg::KERNEL_SIZE + b.tap_col] = v;
               loads_applied++;
            end else begin
               beats_ignored++;
            end
         end
         c2rs_pkg::CMD_BIAS: begin
            if (b.filter_index < c2rs_pkg::FILTER_COUNT) begin
               biases[b.filter_index] = v;
               loads_applied++;
            end else begin
               beats_ignored++;
            end
         end
         c2rs_pkg::CMD_SAMPLE: begin
            samples_sent++;
            // Shift the window left, then pull the new column from the line store.
            for (int k = 0; k < c2rs_pkg::KERNEL_SIZE; k++)
               for (int j = 0; j + 1 < c2rs_pkg::KERNEL_SIZE; j++)
                  window[k * c2rs_pkg::KERNEL_SIZE + j] =
                     window[k * c2rs_pkg::KERNEL_SIZE + j + 1];
            for (int k = 0; k < c2rs_pkg::LINES; k++)
               window[k * c2rs_pkg::KERNEL_SIZE + c2rs_pkg::KERNEL_SIZE - 1] =
                  line_mem[k][pos_col];
            window[c2rs_pkg::TAPS - 1] = v;
            for (int k = 0; k + 1 < c2rs_pkg::LINES; k++)
               line_mem[k][pos_col] = line_mem[k + 1][pos_col];
            line_mem[c2rs_pkg::LINES - 1][pos_col] = v;

            // A full window gives one activation per filter, lowest filter first.
            if (pos_row >= c2rs_pkg::KERNEL_SIZE - 1 &&
                pos_col >= c2rs_pkg::KERNEL_SIZE - 1) begin
               for (int f = 0; f < c2rs_pkg::FILTER_COUNT; f++) begin
                  acc = '0;
                  for (int k = 0; k < c2rs_pkg::TAPS; k++) begin
                     prod = window[k] * weights[f][k];
                     acc  = acc + word_type'(prod >>> c2rs_pkg::FRAC_BITS);
                  end
                  acc = acc + biases[f];
                  r.filter_id   = c2rs_pkg::FILT_W'(f);
                  r.out_row     = c2rs_pkg::OROW_W'(pos_row - (c2rs_pkg::KERNEL_SIZE - 1));
                  r.out_col     = c2rs_pkg::OCOL_W'(pos_col - (c2rs_pkg::KERNEL_SIZE - 1));
                  r.activation  = acc[c2rs_pkg::DATA_WIDTH-1] ? '0
                                                             : c2rs_pkg::ACT_W'(acc);
                  r.last_of_run = (f == c2rs_pkg::FILTER_COUNT - 1);
                  pending_acts.push_back(r);
               end
            end

            // Raster position, wrapping at the end of the frame.
            pos_col++;
            if (pos_col >= c2rs_pkg::IMAGE_COLS) begin
               pos_col = 0;
               pos_row++;
               if (pos_row >= c2rs_pkg::IMAGE_ROWS) begin
                  pos_row = 0;
               end
            end
         end
         default: beats_ignored++;
      endcase
   endtask

   // Offer one beat after a random gap and hold it until the block takes it.
   task automatic send_beat(input c2rs_pkg::req_type b);
      int gap;
      gap = pick_gap(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_beat  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_window(b);
   endtask

   task automatic send_sample(input value_type v);
      c2rs_pkg::req_type b;
      b = '0;
      b.command = c2rs_pkg::CMD_SAMPLE;
      b.filter_index = c2rs_pkg::FILT_W'($urandom);
      b.tap_row = c2rs_pkg::TAP_W'($urandom);
      b.tap_col = c2rs_pkg::TAP_W'($urandom);
      b.value = v;
      send_beat(b);
   endtask

   task automatic send_weight(input int f, input int row, input int col, input value_type v);
      c2rs_pkg::req_type b;
      b.command = c2rs_pkg::CMD_WEIGHT;
      b.filter_index = c2rs_pkg::FILT_W'(f);
      b.tap_row = c2rs_pkg::TAP_W'(row);
      b.tap_col = c2rs_pkg::TAP_W'(col);
      b.value = v;
      send_beat(b);
   endtask

   task automatic send_bias(input int f, input value_type v);
      c2rs_pkg::req_type b;
      b.command = c2rs_pkg::CMD_BIAS;
      b.filter_index = c2rs_pkg::FILT_W'(f);
      b.tap_row = c2rs_pkg::TAP_W'($urandom);
      b.tap_col = c2rs_pkg::TAP_W'($urandom);
      b.value = v;
      send_beat(b);
   endtask

   // Directed loads at the field extremes, ignored beats, and a few extreme samples.
   task automatic test_coefficient_loads();
      c2rs_pkg::req_type b;
      send_weight(0, 0, 0, 16'sh7FFF);
      send_weight(7, 2, 2, 16'sh8000);
      send_weight(3, 1, 1, 16'sh0100);
      send_weight(4, 1, 1, 16'shFF00);
      // Taps outside the kernel must leave the weights alone.
      send_weight(1, 3, 0, 16'sh7FFF);
      send_weight(1, 0, 3, 16'sh8000);
      send_weight(2, 3, 3, 16'sh1234);
      for (int t = 0; t < c2rs_pkg::TAPS; t++)
         send_weight(2, t / c2rs_pkg::KERNEL_SIZE, t % c2rs_pkg::KERNEL_SIZE, pick_value());
      send_bias(0, 16'sh7FFF);
      send_bias(7, 16'sh8000);
      send_bias(5, 16'sh0080);
      // The unused command code is dropped without a result.
      b.command = CMD_UNUSED;
      b.filter_index = 3'd7;
      b.tap_row = 2'd3;
      b.tap_col = 2'd3;
      b.value = 16'shFFFF;
      send_beat(b);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
   endtask

   // Mostly samples in raster order, mixed with loads and the odd dropped beat.
   task automatic test_random_traffic();
      c2rs_pkg::req_type b;
      int                counted;
      int                roll;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         b.filter_index = c2rs_pkg::FILT_W'($urandom);
         b.tap_row = c2rs_pkg::TAP_W'($urandom_range(0, 3));
         b.tap_col = c2rs_pkg::TAP_W'($urandom_range(0, 3));
         b.value = pick_value();
         if (roll < 72) b.command = c2rs_pkg::CMD_SAMPLE;
         else if (roll < 86) b.command = c2rs_pkg::CMD_WEIGHT;
         else if (roll < 95) b.command = c2rs_pkg::CMD_BIAS;
         else b.command = CMD_UNUSED;
         send_beat(b);
         if (b.command == c2rs_pkg::CMD_SAMPLE || b.command == c2rs_pkg::CMD_BIAS ||
             (b.command == c2rs_pkg::CMD_WEIGHT && b.tap_row < c2rs_pkg::KERNEL_SIZE &&
              b.tap_col < c2rs_pkg::KERNEL_SIZE))
            counted++;
      end
   endtask

   // Hold the result side off while samples keep coming, so the input must stall.
   task automatic test_output_backpressure();
      hold_requests++;
      repeat (16) send_sample(pick_value());
   endtask

   // Switch each side between random idling and full rate now and then.
   initial begin
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      forever begin
         repeat ($urandom_range(50, 400)) @(posedge clock);
         if ($urandom_range(0, 1)) req_steady = !req_steady;
         else rsp_steady = !rsp_steady;
      end
   end

   // Result side ready, with random stalls and the long hold when asked.
   initial begin
      int stall_left;
      int hold_left;
      int holds_served;
      rsp_ready = 1'b0;
      stall_left = 0;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap(rsp_steady);
         end
      end
   end

   // Compare every accepted result with the oldest expected activation.
   initial begin
      c2rs_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_acts.size() == 0) begin
               report_mismatch("result with nothing expected, filter_id",
                               rsp_beat.filter_id, -1);
            end else begin
               want = pending_acts.pop_front();
               if (rsp_beat.filter_id !== want.filter_id)
                  report_mismatch("filter_id", rsp_beat.filter_id, want.filter_id);
               if (rsp_beat.out_row !== want.out_row)
                  report_mismatch("out_row", rsp_beat.out_row, want.out_row);
               if (rsp_beat.out_col !== want.out_col)
                  report_mismatch("out_col", rsp_beat.out_col, want.out_col);
               if (rsp_beat.activation !== want.activation)
                  report_mismatch("activation", rsp_beat.activation, want.activation);
               if (rsp_beat.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_beat.last_of_run, want.last_of_run);
            end
            results_checked++;
         end
      end
   end

   // Watchdog: end the run if no beat moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      hold_requests = 0;
      error_count = 0;
      results_checked = 0;
      samples_sent = 0;
      loads_applied = 0;
      beats_ignored = 0;
      pos_row = 0;
      pos_col = 0;
      for (int k = 0; k < c2rs_pkg::LINES; k++)
         for (int c = 0; c < c2rs_pkg::IMAGE_COLS; c++) line_mem[k][c] = '0;
      for (int t = 0; t < c2rs_pkg::TAPS; t++) window[t] = '0;
      for (int f = 0; f < c2rs_pkg::FILTER_COUNT; f++) begin
         biases[f] = '0;
         for (int t = 0; t < c2rs_pkg::TAPS; t++) weights[f][t] = '0;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_coefficient_loads();
      test_random_traffic();
      test_output_backpressure();

      // Let the last results drain, then give stray results a chance to show.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_acts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples, %0d loads and %0d dropped beats, with a %0d-cycle hold.",
               samples_sent, loads_applied, beats_ignored, HOLD_CYCLES);
      $display("Checked %0d results; %0d mismatches.", results_checked, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
